>>> design/msp_frame_encoder_unit_assert.svh
// Assertion macros for the frame encoder.
`ifndef MSP_FRAME_ENCODER_UNIT_ASSERT_SVH
`define MSP_FRAME_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define MFE_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define MFE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/mfe_pkg.sv
`default_nettype none
package mfe_pkg;

    localparam int MaxResults = 9;
    localparam int CntW       = 4;
    localparam int InDataW    = 56;

    localparam logic [7:0] StartChar    = 8'h24;
    localparam logic [7:0] ByteMask     = 8'hFF;
    localparam logic [7:0] CrcPoly      = 8'hD5;
    localparam logic [7:0] MagicV1Reset = 8'd77;
    localparam logic [7:0] MagicV2Reset = 8'd88;
    localparam logic [7:0] FlagByte     = 8'h00;

    localparam logic OpStart   = 1'b0;
    localparam logic OpPayload = 1'b1;

    localparam logic [7:0] CfgMagicV1 = 8'd0;
    localparam logic [7:0] CfgMagicV2 = 8'd1;

    typedef struct packed {
        logic        opcode;
        logic        version;
        logic [7:0]  direction;
        logic [15:0] command;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic [7:0]  hdr_crc;   // CRC over flag and command bytes
    } t_item;

    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [CntW-1:0]            cnt;
        logic                       done;
        logic                       err;
    } t_burst;

    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
        end
        return c & ByteMask;
    endfunction

endpackage
`default_nettype wire

>>> design/mfe_in_stage.sv
`default_nettype none
module mfe_in_stage (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_opcode,
    input  wire logic [mfe_pkg::InDataW-1:0]  i_data,
    output logic                              o_valid,
    output mfe_pkg::t_item                    o_item,
    input  wire logic                         i_take
);

    logic           r_valid;
    mfe_pkg::t_item r_item;
    mfe_pkg::t_item n_item;
    logic [7:0]     w_crc_lo;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // flag byte is zero, so the CRC after it stays zero
    assign w_crc_lo = mfe_pkg::crc8_step(mfe_pkg::FlagByte, i_data[16:9]);

    always_comb begin
        n_item           = '0;
        n_item.opcode    = i_opcode;
        n_item.version   = i_data[0];
        n_item.direction = i_data[8:1];
        n_item.command   = i_data[24:9];
        n_item.length    = i_data[40:25];
        n_item.data_byte = i_data[48:41];
        n_item.hdr_crc   = mfe_pkg::crc8_step(w_crc_lo, i_data[24:17]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

>>> design/mfe_frame_builder.sv
`default_nettype none
module mfe_frame_builder (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [7:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    input  wire mfe_pkg::t_item  i_item,
    input  wire logic            i_load,
    output mfe_pkg::t_burst      o_burst
);

    logic        w_sel_magic1;
    logic [7:0]  r_magic1;
    logic [7:0]  r_magic2;
    logic        r_open;
    logic        r_v2;
    logic [15:0] r_left;
    logic [7:0]  r_check;

    logic        n_open;
    logic        n_v2;
    logic [15:0] n_left;
    logic [7:0]  n_check;

    logic [7:0]  w_crc_len_lo;
    logic [7:0]  w_crc_hdr;
    logic [7:0]  w_v1_check;
    logic [7:0]  w_pay_check;
    logic        w_len_zero;
    logic        w_start_err;

    mfe_pkg::t_burst n_burst;

    assign w_crc_len_lo = mfe_pkg::crc8_step(i_item.hdr_crc, i_item.length[7:0]);
    assign w_crc_hdr    = mfe_pkg::crc8_step(w_crc_len_lo, i_item.length[15:8]);
    assign w_v1_check   = i_item.length[7:0] ^ i_item.command[7:0];
    assign w_pay_check  = r_v2 ? mfe_pkg::crc8_step(r_check, i_item.data_byte)
                               : (r_check ^ i_item.data_byte);
    assign w_len_zero   = (i_item.length == 16'd0);
    assign w_start_err  = r_open || (!i_item.version && (i_item.length[15:8] != 8'd0));

    always_comb begin
        n_burst = '0;
        n_open  = r_open;
        n_v2    = r_v2;
        n_left  = r_left;
        n_check = r_check;
        unique case (i_item.opcode)
            mfe_pkg::OpStart: begin
                if (w_start_err) begin
                    n_burst.cnt = mfe_pkg::CntW'(1);
                    n_burst.err = 1'b1;
                end else begin
                    n_v2     = i_item.version;
                    n_left   = i_item.length;
                    n_open   = !w_len_zero;
                    n_burst.bytes[0] = mfe_pkg::StartChar;
                    n_burst.bytes[2] = i_item.direction;
                    n_burst.done     = w_len_zero;
                    if (i_item.version) begin
                        n_check          = w_crc_hdr;
                        n_burst.bytes[1] = r_magic2;
                        n_burst.bytes[3] = mfe_pkg::FlagByte;
                        n_burst.bytes[4] = i_item.command[7:0];
                        n_burst.bytes[5] = i_item.command[15:8];
                        n_burst.bytes[6] = i_item.length[7:0];
                        n_burst.bytes[7] = i_item.length[15:8];
                        n_burst.bytes[8] = w_crc_hdr;
                        n_burst.cnt      = w_len_zero ? mfe_pkg::CntW'(9)
                                                      : mfe_pkg::CntW'(8);
                    end else begin
                        n_check          = w_v1_check;
                        n_burst.bytes[1] = r_magic1;
                        n_burst.bytes[3] = i_item.length[7:0];
                        n_burst.bytes[4] = i_item.command[7:0];
                        n_burst.bytes[5] = w_v1_check;
                        n_burst.cnt      = w_len_zero ? mfe_pkg::CntW'(6)
                                                      : mfe_pkg::CntW'(5);
                    end
                    if (w_len_zero) begin
                        n_left = 16'd0;
                    end
                end
            end
            mfe_pkg::OpPayload: begin
                if (!r_open) begin
                    n_burst.cnt = mfe_pkg::CntW'(1);
                    n_burst.err = 1'b1;
                end else begin
                    n_check          = w_pay_check;
                    n_left           = r_left - 16'd1;
                    n_burst.bytes[0] = i_item.data_byte;
                    n_burst.bytes[1] = w_pay_check;
                    if (r_left == 16'd1) begin
                        n_open       = 1'b0;
                        n_burst.done = 1'b1;
                        n_burst.cnt  = mfe_pkg::CntW'(2);
                    end else begin
                        n_burst.cnt  = mfe_pkg::CntW'(1);
                    end
                end
            end
            default: begin
                n_burst = '0;
            end
        endcase
    end

    assign o_burst = n_burst;

    // register writes
    assign w_sel_magic1 = (i_cfg_index == mfe_pkg::CfgMagicV1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic1 <= mfe_pkg::MagicV1Reset;
            r_magic2 <= mfe_pkg::MagicV2Reset;
        end else if (i_cfg_valid) begin
            if (w_sel_magic1) begin
                r_magic1 <= i_cfg_data;
            end else if (i_cfg_index == mfe_pkg::CfgMagicV2) begin
                r_magic2 <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_v2    <= 1'b0;
            r_left  <= 16'd0;
            r_check <= 8'd0;
        end else if (i_load) begin
            r_open  <= n_open;
            r_v2    <= n_v2;
            r_left  <= n_left;
            r_check <= n_check;
        end
    end

endmodule
`default_nettype wire

>>> design/mfe_out_burst.sv
`default_nettype none
module mfe_out_burst (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mfe_pkg::t_burst  i_burst,
    input  wire logic             i_load,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_byte,
    output logic                  o_done,
    output logic                  o_err,
    output logic                  o_last
);

    logic [mfe_pkg::MaxResults-1:0][7:0] r_bytes;
    logic [mfe_pkg::CntW-1:0]            r_cnt;
    logic                                r_done;
    logic                                r_err;
    logic                                w_take;

    assign o_valid    = (r_cnt != '0);
    assign w_take     = o_valid && i_ready;
    assign o_last     = (r_cnt == mfe_pkg::CntW'(1));
    assign o_can_load = !o_valid || (o_last && i_ready);
    assign o_byte     = r_bytes[0];
    assign o_done     = r_done && o_last;
    assign o_err      = r_err && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - mfe_pkg::CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_done  <= i_burst.done;
            r_err   <= i_burst.err;
        end else if (w_take) begin
            r_bytes <= r_bytes >> 8;
        end
    end

endmodule
`default_nettype wire

>>> design/msp_frame_encoder_unit.sv
// Channel  Dir  Handshake              Payload
// s        in   i_s_tvalid/o_s_tready  tuser opcode, tdata item fields
// m        out  o_m_tvalid/i_m_tready  tdata out_byte, tuser flags, tlast
// cfg      in   i_cfg_valid/o_cfg_ready  index, magic byte
//
// One output word per cycle; stalls on m hold the current word and back up to s.
// A start item gives 5 to 9 words (1 when rejected), a payload item 1 or 2; the
// single output port sets the rate. Input and output stages are registered. Next
// item is taken while the last word of the current burst leaves. Synchronous
// active-low reset empties both stages and closes any open frame.
`default_nettype none
module msp_frame_encoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // version, direction, command, length, data_byte
    input  wire logic        i_s_tuser,   // opcode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // out_byte
    output logic [1:0]       o_m_tuser,   // frame_done, error
    output logic             o_m_tlast,   // last
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic            w_in_valid;
    mfe_pkg::t_item  w_item;
    mfe_pkg::t_burst w_burst;
    logic            w_can_load;
    logic            w_load;
    logic            w_done;
    logic            w_err;

    assign o_cfg_ready = 1'b1;
    assign w_load      = w_in_valid && w_can_load;
    assign o_m_tuser   = {w_err, w_done};

    mfe_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_opcode (i_s_tuser),
        .i_data   (i_s_tdata),
        .o_valid  (w_in_valid),
        .o_item   (w_item),
        .i_take   (w_load)
    );

    mfe_frame_builder u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_load      (w_load),
        .o_burst     (w_burst)
    );

    mfe_out_burst u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (w_burst),
        .i_load     (w_load),
        .o_can_load (w_can_load),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_byte     (o_m_tdata),
        .o_done     (w_done),
        .o_err      (w_err),
        .o_last     (o_m_tlast)
    );

`include "msp_frame_encoder_unit_assert.svh"

    `MFE_ASSERT_NOW(a_err_word, i_clk, i_rst_n, o_m_tvalid && w_err, o_m_tlast && (o_m_tdata == 8'd0) && !w_done, "error word malformed")
    `MFE_ASSERT_NOW(a_done_last, i_clk, i_rst_n, o_m_tvalid && w_done, o_m_tlast, "checksum not last word")
    `MFE_ASSERT_NEXT(a_burst_kept, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tvalid, "burst cut short")
    `MFE_ASSERT_NOW(a_load_slot, i_clk, i_rst_n, w_load, !o_m_tvalid || (o_m_tlast && i_m_tready), "burst overwritten")

endmodule
`default_nettype wire

>>> tb/msp_frame_encoder_unit_checker.sv
`timescale 1ns / 1ps
module msp_frame_encoder_unit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [55:0] s_tdata,   // version, direction, command, length, data_byte
    input  wire logic        s_tuser,   // opcode
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // out_byte
    input  wire logic [1:0]  m_tuser,   // frame_done, error
    input  wire logic        m_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output int               mismatches,
    output int               pending_words
);

    typedef struct packed {
        logic [7:0] octet;
        logic       done;
        logic       err;
        logic       last;
    } t_wire_word;

    t_wire_word  wire_bytes_q[$];

    logic        in_frame;
    logic        v2_frame;
    logic [15:0] payload_left;
    logic [7:0]  check_acc;
    logic [7:0]  magic1;
    logic [7:0]  magic2;

    function automatic logic [7:0] crc_dvbs2(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ mfe_pkg::CrcPoly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic t_wire_word frame_word(input logic [7:0] b, input logic done,
                                              input logic err);
        t_wire_word w;
        w.octet = b;
        w.done  = done;
        w.err   = err;
        w.last  = 1'b0;
        return w;
    endfunction

    task automatic close_frame();
        wire_bytes_q.push_back(frame_word(check_acc, 1'b1, 1'b0));
        in_frame     = 1'b0;
        payload_left = '0;
    endtask

    task automatic encode_item(input logic op, input logic v2, input logic [7:0] dir,
                               input logic [15:0] cmd, input logic [15:0] len,
                               input logic [7:0] data);
        logic [7:0] hdr [5];
        t_wire_word w;
        if (op == mfe_pkg::OpStart) begin
            if (in_frame || (!v2 && len > 16'd255)) begin
                wire_bytes_q.push_back(frame_word(8'h00, 1'b0, 1'b1));
            end else begin
                in_frame     = 1'b1;
                v2_frame     = v2;
                payload_left = len;
                wire_bytes_q.push_back(frame_word(mfe_pkg::StartChar, 1'b0, 1'b0));
                if (v2) begin
                    hdr[0] = mfe_pkg::FlagByte;
                    hdr[1] = cmd[7:0];
                    hdr[2] = cmd[15:8];
                    hdr[3] = len[7:0];
                    hdr[4] = len[15:8];
                    wire_bytes_q.push_back(frame_word(magic2, 1'b0, 1'b0));
                    wire_bytes_q.push_back(frame_word(dir, 1'b0, 1'b0));
                    check_acc = 8'h00;
                    for (int i = 0; i < 5; i++) begin
                        wire_bytes_q.push_back(frame_word(hdr[i], 1'b0, 1'b0));
                        check_acc = crc_dvbs2(check_acc, hdr[i]);
                    end
                end else begin
                    wire_bytes_q.push_back(frame_word(magic1, 1'b0, 1'b0));
                    wire_bytes_q.push_back(frame_word(dir, 1'b0, 1'b0));
                    wire_bytes_q.push_back(frame_word(len[7:0], 1'b0, 1'b0));
                    wire_bytes_q.push_back(frame_word(cmd[7:0], 1'b0, 1'b0));
                    check_acc = len[7:0] ^ cmd[7:0];
                end
                if (len == 16'd0) begin
                    close_frame();
                end
            end
        end else if (!in_frame) begin
            wire_bytes_q.push_back(frame_word(8'h00, 1'b0, 1'b1));
        end else begin
            wire_bytes_q.push_back(frame_word(data, 1'b0, 1'b0));
            check_acc    = v2_frame ? crc_dvbs2(check_acc, data) : (check_acc ^ data);
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) begin
                close_frame();
            end
        end
        // tlast marks the final word of this burst
        w = wire_bytes_q.pop_back();
        w.last = 1'b1;
        wire_bytes_q.push_back(w);
    endtask

    always @(posedge clk) begin : watch
        t_wire_word want;
        if (!rst_n) begin
            wire_bytes_q.delete();
            in_frame     = 1'b0;
            v2_frame     = 1'b0;
            payload_left = '0;
            check_acc    = '0;
            magic1       = mfe_pkg::MagicV1Reset;
            magic2       = mfe_pkg::MagicV2Reset;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == mfe_pkg::CfgMagicV1) begin
                    magic1 = cfg_data;
                end else if (cfg_index == mfe_pkg::CfgMagicV2) begin
                    magic2 = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                encode_item(s_tuser, s_tdata[0], s_tdata[8:1], s_tdata[24:9],
                            s_tdata[40:25], s_tdata[48:41]);
            end
            if (m_tvalid && m_tready) begin
                if (wire_bytes_q.size() == 0) begin
                    $error("unexpected word: out_byte %0h tuser %0b last %0b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = wire_bytes_q.pop_front();
                    if (m_tdata !== want.octet) begin
                        $error("out_byte: expected %0h, got %0h", want.octet, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.done) begin
                        $error("frame_done: expected %0b, got %0b", want.done, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== want.err) begin
                        $error("error: expected %0b, got %0b", want.err, m_tuser[1]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        pending_words = wire_bytes_q.size();
    end

endmodule

>>> tb/msp_frame_encoder_unit_tb.sv
`timescale 1ns / 1ps
module msp_frame_encoder_unit_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;

    int          mismatches;
    int          pending_words;
    int          src_gap_pct;
    int          sink_stall_pct;
    int          words_sent;

    msp_frame_encoder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    msp_frame_encoder_unit_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_item(input logic op, input logic v2, input logic [7:0] dir,
                             input logic [15:0] cmd, input logic [15:0] len,
                             input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, data, len, cmd, dir, v2};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic start_frame(input logic v2, input logic [7:0] dir,
                               input logic [15:0] cmd, input logic [15:0] len);
        push_item(mfe_pkg::OpStart, v2, dir, cmd, len, 8'($urandom_range(255)));
    endtask

    task automatic payload_byte(input logic [7:0] data);
        push_item(mfe_pkg::OpPayload, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)), data);
    endtask

    // drop valid, wait for the output side to drain, then let the pipe settle
    task automatic settle_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int upto);
        int k;
        int len;
        while (words_sent < upto) begin
            k = $urandom_range(99);
            if (k < 6) begin
                payload_byte(8'($urandom_range(255)));
            end else if (k < 10) begin
                start_frame(1'b0, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                            16'(256 + $urandom_range(65279)));
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6);
                start_frame(1'($urandom_range(1)), 8'($urandom_range(255)),
                            16'($urandom_range(65535)), 16'(len));
                repeat (len) begin
                    if ($urandom_range(99) < 4) begin
                        start_frame(1'($urandom_range(1)), 8'($urandom_range(255)),
                                    16'($urandom_range(65535)), 16'($urandom_range(65535)));
                    end
                    payload_byte(8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        words_sent     = 0;
        src_gap_pct    = 11;
        sink_stall_pct = 51;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // error paths and header extremes at reset magic values
        payload_byte(8'hFF);
        start_frame(1'b0, 8'h00, 16'h0000, 16'hFFFF);
        start_frame(1'b0, 8'h00, 16'h0000, 16'd256);
        start_frame(1'b0, 8'hFF, 16'hFFFF, 16'd0);
        start_frame(1'b1, 8'h00, 16'hFFFF, 16'd0);
        start_frame(1'b1, 8'hFF, 16'h0000, 16'd0);
        start_frame(1'b0, 8'h3C, 16'h00A5, 16'd3);
        start_frame(1'b1, 8'h11, 16'h2222, 16'd0);
        payload_byte(8'h00);
        payload_byte(8'hFF);
        payload_byte(8'h5A);
        start_frame(1'b1, 8'h01, 16'h1234, 16'd2);
        start_frame(1'b0, 8'h02, 16'h0001, 16'd300);
        payload_byte(8'hFF);
        payload_byte(8'h80);
        payload_byte(8'h00);
        start_frame(1'b1, 8'h7E, 16'h8001, 16'd1);
        payload_byte(8'hC3);

        write_reg(mfe_pkg::CfgMagicV1, 8'hFF);
        write_reg(mfe_pkg::CfgMagicV2, 8'h00);
        run_traffic(110);

        src_gap_pct    = 51;
        sink_stall_pct = 11;
        write_reg(mfe_pkg::CfgMagicV1, 8'h00);
        write_reg(mfe_pkg::CfgMagicV2, 8'hFF);
        run_traffic(200);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        write_reg(mfe_pkg::CfgMagicV1, 8'($urandom_range(255)));
        write_reg(mfe_pkg::CfgMagicV2, 8'($urandom_range(255)));
        start_frame(1'b0, 8'($urandom_range(255)), 16'($urandom_range(65535)), 16'd110);
        repeat (110) payload_byte(8'($urandom_range(255)));
        run_traffic(320);

        settle_idle();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending_words == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/mfe_pkg.sv
design/mfe_in_stage.sv
design/mfe_frame_builder.sv
design/mfe_out_burst.sv
design/msp_frame_encoder_unit.sv
tb/msp_frame_encoder_unit_checker.sv
tb/msp_frame_encoder_unit_tb.sv
